FILE: sv/cct_pkg.sv
`timescale 1ns / 1ps
// cct_pkg: types, constants and mate score helpers for the clustered
// transposition table; no dependencies
package cct_pkg;

  localparam int CLUSTERS    = 4096;   // power of two, cluster index is the low hash bits
  localparam int WAYS        = 4;
  localparam int MATE_SCORE  = 32000;
  localparam int MATE_WINDOW = 512;

  localparam int CIDX_W = $clog2(CLUSTERS);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W  = 32;
  localparam int GEN_W  = 6;

  localparam logic [1:0] BOUND_EXACT = 2'd3;
  localparam logic signed [11:0] DEPTH_SLACK = 12'sd2;
  localparam logic signed [9:0]  DEPTH_MAX   = 10'sd255;

  localparam logic signed [17:0] MATE_LO = 18'(MATE_SCORE - MATE_WINDOW);
  localparam logic signed [17:0] SAT_HI  = 18'sd32767;
  localparam logic signed [17:0] SAT_LO  = -18'sd32768;

  typedef enum logic [1:0] {
    OP_PROBE      = 2'd0,
    OP_SAVE       = 2'd1,
    OP_NEW_SEARCH = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic signed [15:0]  score;
    logic signed [15:0]  pos_eval;
    logic [15:0]         move;
    logic [7:0]          depth;
    logic [1:0]          bound;
    logic [GEN_W-1:0]    gen;
  } entry_t;

  typedef entry_t [WAYS-1:0] cluster_t;

  localparam int CLUSTER_W = $bits(cluster_t);

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
  } lookup_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > SAT_HI) return 16'sh7fff;
    else if (v < SAT_LO) return 16'sh8000;
    else return v[15:0];
  endfunction

  // mate distance from root -> distance from this node
  function automatic logic signed [15:0] to_table(input logic signed [15:0] s,
                                                  input logic [7:0] ply);
    logic signed [17:0] s18;
    logic signed [17:0] p18;
    s18 = 18'(s);
    p18 = $signed({10'b0, ply});
    if (s18 >= MATE_LO) return sat16(s18 + p18);
    else if (s18 <= -MATE_LO) return sat16(s18 - p18);
    else return s;
  endfunction

  // mate distance from this node -> distance from root
  function automatic logic signed [15:0] from_table(input logic signed [15:0] s,
                                                    input logic [7:0] ply);
    logic signed [17:0] s18;
    logic signed [17:0] p18;
    s18 = 18'(s);
    p18 = $signed({10'b0, ply});
    if (s18 >= MATE_LO) return sat16(s18 - p18);
    else if (s18 <= -MATE_LO) return sat16(s18 + p18);
    else return s;
  endfunction

endpackage

FILE: sv/cct_if.sv
`timescale 1ns / 1ps
// cct_if: request and result channel interfaces of the transposition table
// depends on cct_pkg
interface cct_req_if;
  logic               valid;
  logic               ready;
  cct_pkg::op_t       operation;
  logic [63:0]        hash;
  logic signed [15:0] score;
  logic signed [15:0] pos_eval;
  logic [15:0]        move_code;
  logic signed [9:0]  depth;
  logic [1:0]         bound;
  logic [7:0]         ply;

  modport source(output valid, operation, hash, score, pos_eval, move_code,
                 depth, bound, ply, input ready);
  modport sink(input valid, operation, hash, score, pos_eval, move_code,
               depth, bound, ply, output ready);
endinterface

interface cct_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic               stored;
  logic signed [15:0] out_score;
  logic signed [15:0] out_eval;
  logic [15:0]        out_move;
  logic [7:0]         out_depth;
  logic [1:0]         out_bound;

  modport source(output valid, hit, stored, out_score, out_eval, out_move,
                 out_depth, out_bound, input ready);
  modport sink(input valid, hit, stored, out_score, out_eval, out_move,
               out_depth, out_bound, output ready);
endinterface

FILE: sv/cct_ram.sv
`timescale 1ns / 1ps
// cct_ram: simple dual port synchronous ram, registered read
// no dependencies
module cct_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/cct_lookup.sv
`timescale 1ns / 1ps
// cct_lookup: tag match and replacement way choice over one cluster
// depends on cct_pkg
module cct_lookup (
  input  cct_pkg::cluster_t             cluster,
  input  logic [cct_pkg::TAG_W-1:0]     tag,
  input  logic [cct_pkg::GEN_W-1:0]     generation,
  output cct_pkg::lookup_t              result
);

  always_comb begin
    logic [7:0]                best;
    logic [7:0]                eff;
    logic [cct_pkg::WAY_W-1:0] rep;
    logic [cct_pkg::WAY_W-1:0] match_way;
    logic                      found;
    best      = (cluster[0].gen == generation) ? cluster[0].depth : 8'd0;
    rep       = '0;
    match_way = '0;
    found     = 1'b0;
    for (int i = 0; i < cct_pkg::WAYS; i++) begin
      eff = (cluster[i].gen == generation) ? cluster[i].depth : 8'd0;
      if (!found && cluster[i].tag == tag) begin
        found     = 1'b1;
        match_way = cct_pkg::WAY_W'(i);
      end
      // first lowest effective depth wins
      if (best > eff) begin
        best = eff;
        rep  = cct_pkg::WAY_W'(i);
      end
    end
    result.hit = found;
    result.way = found ? match_way : rep;
  end

endmodule

FILE: sv/clustered_transposition_table_top.sv
`timescale 1ns / 1ps
// a request is latched and its cluster read; its result registers once the result slot is free
// one request at a time: its cluster is read, then written back in one ram, before another is taken
// clear table: after its result, a clearing pass of 4096 clusters (one cluster a cycle), no requests
// reset: synchronous; starts the same clearing pass and zeroes the generation
// depends on cct_pkg, cct_if, cct_ram, cct_lookup
module clustered_transposition_table_top (
  input  logic      clk,
  input  logic      rst,
  cct_req_if.sink   req,
  cct_rsp_if.source rsp
);

  // control state
  cct_pkg::state_t               state;
  cct_pkg::state_t               state_next;
  logic [cct_pkg::CIDX_W-1:0]    clr_idx;
  logic [cct_pkg::GEN_W-1:0]     generation;
  logic                          rsp_valid;

  // latched request
  cct_pkg::op_t                  cur_op;
  logic [cct_pkg::CIDX_W-1:0]    cur_idx;
  logic [cct_pkg::TAG_W-1:0]     cur_tag;
  logic signed [15:0]            cur_score;
  logic signed [15:0]            cur_seval;
  logic [15:0]                   cur_move;
  logic signed [9:0]             cur_depth;
  logic [1:0]                    cur_bound;
  logic [7:0]                    cur_ply;

  // result register
  logic                          rsp_hit;
  logic                          rsp_stored;
  logic signed [15:0]            rsp_score;
  logic signed [15:0]            rsp_seval;
  logic [15:0]                   rsp_move;
  logic [7:0]                    rsp_depth;
  logic [1:0]                    rsp_bound;

  // ram side
  logic                          mem_we;
  logic [cct_pkg::CIDX_W-1:0]    mem_waddr;
  logic [cct_pkg::CLUSTER_W-1:0] mem_wdata;
  logic [cct_pkg::CLUSTER_W-1:0] mem_rdata;
  logic                          req_fire;
  logic                          exec_fire;

  cct_pkg::cluster_t             rd_cluster;
  cct_pkg::cluster_t             wr_cluster;
  cct_pkg::entry_t               way_entry;
  cct_pkg::entry_t               new_entry;
  cct_pkg::lookup_t              lk;
  logic                          skip;
  logic signed [11:0]            depth_lim;
  logic [7:0]                    depth_clamp;

  assign req.ready = (state == cct_pkg::ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  // the executing request finishes once the result slot is free
  assign exec_fire = (state == cct_pkg::ST_EXEC) && (!rsp_valid || rsp.ready);

  cct_ram #(
    .DEPTH(cct_pkg::CLUSTERS),
    .WIDTH(cct_pkg::CLUSTER_W)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (req_fire),
    .raddr(req.hash[cct_pkg::CIDX_W-1:0]),
    .rdata(mem_rdata)
  );

  assign rd_cluster = cct_pkg::cluster_t'(mem_rdata);

  cct_lookup u_lookup (
    .cluster   (rd_cluster),
    .tag       (cur_tag),
    .generation(generation),
    .result    (lk)
  );

  assign way_entry = rd_cluster[lk.way];

  // keep a matching entry over DEPTH_SLACK deeper than a non-exact save; test uses the unclamped request depth
  assign depth_lim = 12'(cur_depth) + cct_pkg::DEPTH_SLACK;
  assign skip = lk.hit && (cur_bound != cct_pkg::BOUND_EXACT) &&
                ($signed({4'b0, way_entry.depth}) > depth_lim);

  always_comb begin
    if (cur_depth < 10'sd0) depth_clamp = 8'd0;
    else if (cur_depth > cct_pkg::DEPTH_MAX) depth_clamp = 8'd255;
    else depth_clamp = cur_depth[7:0];
  end

  always_comb begin
    new_entry.tag         = cur_tag;
    new_entry.score       = cct_pkg::to_table(cur_score, cur_ply);
    new_entry.pos_eval    = cur_seval;
    new_entry.move        = cur_move;
    new_entry.depth       = depth_clamp;
    new_entry.bound       = cur_bound;
    new_entry.gen         = generation;
    wr_cluster            = rd_cluster;
    wr_cluster[lk.way]    = new_entry;
  end

  // next state and ram write port
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cur_idx;
    mem_wdata  = wr_cluster;
    unique case (state)
      cct_pkg::ST_CLEAR: begin
        // zero one cluster a cycle
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
        if (clr_idx == cct_pkg::CIDX_W'(cct_pkg::CLUSTERS - 1)) begin
          state_next = cct_pkg::ST_IDLE;
        end
      end
      cct_pkg::ST_IDLE: begin
        if (req_fire) begin
          state_next = cct_pkg::ST_EXEC;
        end
      end
      cct_pkg::ST_EXEC: begin
        if (exec_fire) begin
          mem_we     = (cur_op == cct_pkg::OP_SAVE) && !skip;
          state_next = (cur_op == cct_pkg::OP_CLEAR) ? cct_pkg::ST_CLEAR : cct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cct_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cct_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sweep counter restarts on every entry into the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == cct_pkg::ST_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end else begin
      clr_idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generation <= '0;
    end else if (exec_fire) begin
      if (cur_op == cct_pkg::OP_NEW_SEARCH) begin
        generation <= generation + 1'b1;
      end else if (cur_op == cct_pkg::OP_CLEAR) begin
        generation <= '0;
      end
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_fire) begin
      cur_op    <= req.operation;
      cur_idx   <= req.hash[cct_pkg::CIDX_W-1:0];
      cur_tag   <= req.hash[cct_pkg::TAG_W-1:0];
      cur_score <= req.score;
      cur_seval <= req.pos_eval;
      cur_move  <= req.move_code;
      cur_depth <= req.depth;
      cur_bound <= req.bound;
      cur_ply   <= req.ply;
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp_hit    <= ((cur_op == cct_pkg::OP_PROBE) || (cur_op == cct_pkg::OP_SAVE)) && lk.hit;
      rsp_stored <= (cur_op == cct_pkg::OP_SAVE) && !skip;
      if ((cur_op == cct_pkg::OP_PROBE) && lk.hit) begin
        rsp_score <= cct_pkg::from_table(way_entry.score, cur_ply);
        rsp_seval <= way_entry.pos_eval;
        rsp_move  <= way_entry.move;
        rsp_depth <= way_entry.depth;
        rsp_bound <= way_entry.bound;
      end else begin
        rsp_score <= '0;
        rsp_seval <= '0;
        rsp_move  <= '0;
        rsp_depth <= '0;
        rsp_bound <= '0;
      end
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.hit       = rsp_hit;
  assign rsp.stored    = rsp_stored;
  assign rsp.out_score = rsp_score;
  assign rsp.out_eval  = rsp_seval;
  assign rsp.out_move  = rsp_move;
  assign rsp.out_depth = rsp_depth;
  assign rsp.out_bound = rsp_bound;

endmodule

FILE: sv/cct_checker.sv
`timescale 1ns / 1ps
// cct_checker: port level assertions for the transposition table
// bound to clustered_transposition_table_top
module cct_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              hit,
  input logic signed [15:0] out_score,
  input logic signed [15:0] out_eval,
  input logic [15:0]       out_move,
  input logic [7:0]        out_depth,
  input logic [1:0]        out_bound
);

  // reset starts the clearing pass, no requests right after
  a_reset_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request ready right after reset");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) (req_valid && req_ready) |=> !req_ready)
    else $error("ready again right after a request");

  // a new result only comes from a request in flight
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result appeared without a request in flight");

  // entry fields are zero except on a hit
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !hit) |-> (out_score == 16'sd0 && out_eval == 16'sd0 &&
                             out_move == 16'd0 && out_depth == 8'd0 && out_bound == 2'd0))
    else $error("nonzero entry fields without a hit");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped while stalled");

endmodule

bind clustered_transposition_table_top cct_checker u_cct_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .hit      (rsp.hit),
  .out_score(rsp.out_score),
  .out_eval (rsp.out_eval),
  .out_move (rsp.out_move),
  .out_depth(rsp.out_depth),
  .out_bound(rsp.out_bound)
);
